[rtl/task_period_exec_time_profiler_core_macros.svh]
// assertion macros for the task profiler, sampled on clk_i and quiet during reset
`ifndef TASK_PERIOD_EXEC_TIME_PROFILER_CORE_MACROS_SVH
`define TASK_PERIOD_EXEC_TIME_PROFILER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TPP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define TPP_ASSERT(lbl, prop, msg)

`define TPP_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

[rtl/tpp_pkg.sv]
package tpp_pkg;

  localparam int unsigned TASKS   = 4;
  localparam int unsigned TASK_W  = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned STAMP_W = 16;

  localparam logic KIND_PERIOD = 1'b0;
  localparam logic KIND_EXEC   = 1'b1;

  localparam logic [STAMP_W-1:0] STAMP_ONES = {STAMP_W{1'b1}};

  typedef struct packed {
    logic [STAMP_W-1:0] last_start;
    logic               period_armed;
    logic               exec_armed;
    logic [STAMP_W-1:0] period_min;
    logic [STAMP_W-1:0] period_max;
    logic [STAMP_W-1:0] exec_min;
    logic [STAMP_W-1:0] exec_max;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    last_start:   '0,
    period_armed: 1'b0,
    exec_armed:   1'b0,
    period_min:   STAMP_ONES,
    period_max:   '0,
    exec_min:     STAMP_ONES,
    exec_max:     '0
  };

  // wrapping distance between two timer stamps, one less than the modular difference when newer is not above older
  function automatic logic [STAMP_W-1:0] span16(input logic [STAMP_W-1:0] older,
                                                input logic [STAMP_W-1:0] newer);
    logic [STAMP_W-1:0] diff;
    diff = newer - older;
    if (newer > older) begin
      span16 = diff;
    end else begin
      span16 = diff - {{(STAMP_W-1){1'b0}}, 1'b1};
    end
  endfunction

endpackage

[rtl/task_period_exec_time_profiler_core.sv]
// Per-task period and execution time profiler.
// Input channel: raise start_i with req_type_i (0 task start, 1 task end), task_id_i
// and stamp_i; the item is taken at a clock edge where start_i is high and busy_o low.
// Every item gives one result: res_valid_o is high for exactly one cycle, with
// task_echo_o, kind_o, measured_o, interval_o, interval_min_o and interval_max_o.
// The receiver cannot stall; results stay on the ports until the next result.
// The result is registered from the calc state (busy_o high) entered at the accepting edge.
// Items do not overlap: busy_o is high for the one cycle in which the task's
// table entry, read from the statistics memory (separate read and write ports)
// the cycle before, is updated and written back while measurement is enabled.
// Configuration: cfg_data_i[0] is measure_enable, written when cfg_valid_i and
// cfg_ready_o are both high (cfg_ready_o is always high); write it only while idle.
// Reset (rst_ni low, asynchronous) disables measurement, drops any item in work,
// and marks every table entry as empty, so it reads as cleared statistics
// (min 0xFFFF, max 0, nothing armed) until first written. No clearing pass.
`include "task_period_exec_time_profiler_core_macros.svh"

module task_period_exec_time_profiler_core
  import tpp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [TASK_W-1:0]  task_id_i,
  input  logic [STAMP_W-1:0] stamp_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  output logic               res_valid_o,
  output logic [TASK_W-1:0]  task_echo_o,
  output logic               kind_o,
  output logic               measured_o,
  output logic [STAMP_W-1:0] interval_o,
  output logic [STAMP_W-1:0] interval_min_o,
  output logic [STAMP_W-1:0] interval_max_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic               state_q, state_d;
  logic               enable_q;
  logic               accept;
  logic               kind_q;
  logic [TASK_W-1:0]  task_q;
  logic [STAMP_W-1:0] stamp_q;

  entry_t             mem_q [TASKS];
  entry_t             rd_q;
  logic [TASKS-1:0]   vld_q;

  entry_t             cur;
  entry_t             nxt;
  logic [STAMP_W-1:0] span;
  logic               meas;
  logic [STAMP_W-1:0] lo, hi;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q == ST_CALC);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_CALC;
      end
      ST_CALC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      enable_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) enable_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= req_type_i;
      task_q  <= task_id_i;
      stamp_q <= stamp_i;
    end
  end

  // statistics memory: one read port at accept, one write port at the end of calc
  always_ff @(posedge clk_i) begin
    if (accept) rd_q <= mem_q[task_id_i];
  end

  always_ff @(posedge clk_i) begin
    if (busy_o && enable_q) mem_q[task_q] <= nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (busy_o && enable_q) begin
      vld_q[task_q] <= 1'b1;
    end
  end

  always_comb begin
    cur  = vld_q[task_q] ? rd_q : ENTRY_RESET;
    nxt  = cur;
    meas = 1'b0;
    span = span16(cur.last_start, stamp_q);
    if (enable_q) begin
      if (kind_q == KIND_PERIOD) begin
        nxt.exec_armed = 1'b1;
        nxt.last_start = stamp_q;
        if (cur.period_armed) begin
          meas = 1'b1;
          if (span < cur.period_min) nxt.period_min = span;
          if (span > cur.period_max) nxt.period_max = span;
        end else begin
          nxt.period_armed = 1'b1;
        end
      end else if (cur.exec_armed) begin
        meas = 1'b1;
        if (span < cur.exec_min) nxt.exec_min = span;
        if (span > cur.exec_max) nxt.exec_max = span;
      end
    end
    lo = (kind_q == KIND_PERIOD) ? nxt.period_min : nxt.exec_min;
    hi = (kind_q == KIND_PERIOD) ? nxt.period_max : nxt.exec_max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      task_echo_o    <= task_q;
      kind_o         <= kind_q;
      measured_o     <= meas;
      interval_o     <= meas ? span : '0;
      interval_min_o <= lo;
      interval_max_o <= hi;
    end
  end

  `TPP_ASSERT(a_accept_calc, accept |=> busy_o, "accepted item did not enter calc")
  `TPP_ASSERT(a_calc_single, busy_o |=> (!busy_o && res_valid_o), "calc did not finish in one cycle")
  `TPP_ASSERT_IMPL(a_res_from_calc, res_valid_o, $past(busy_o), "result strobe without calc")
  `TPP_ASSERT_IMPL(a_unmeasured_zero, res_valid_o && !measured_o, interval_o == '0,
                   "interval not zero without measurement")
  `TPP_ASSERT_IMPL(a_measured_bounds, res_valid_o && measured_o,
                   (interval_min_o <= interval_o) && (interval_o <= interval_max_o),
                   "measured interval outside stored min and max")

endmodule
